// ----- hw/rtl/hover_thrust_kalman_estimator_unit_defines.svh -----
// Assertion macros for the hover thrust estimator.
`ifndef HOVER_THRUST_KALMAN_ESTIMATOR_UNIT_DEFINES_SVH
`define HOVER_THRUST_KALMAN_ESTIMATOR_UNIT_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define HTK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Asserts that a condition holds in the cycle after another one.
`define HTK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ----- hw/rtl/htk_pkg.sv -----
// Package with types, constants and codes of the hover thrust estimator.
package htk_pkg;
  localparam int DataFracBits = 16;
  localparam int CovFracBits = 24;
  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_CORRECT = 2'd1;
  localparam logic [1:0] CMD_SET = 2'd2;
  localparam logic [1:0] FLAG_NONE = 2'd0;
  localparam logic [1:0] FLAG_LOW = 2'd1;
  localparam logic [1:0] FLAG_HIGH = 2'd2;
  localparam logic [1:0] FLAG_ZERO_VAR = 2'd3;
  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_LO = 3'd1;
  localparam logic [2:0] REG_HI = 3'd2;
  localparam logic [2:0] REG_NOISE = 3'd3;
  localparam logic [2:0] REG_GRAV = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_G2, ST_P_OFF, ST_P_ACC, ST_P_P11,
    ST_C_S, ST_C_K0, ST_C_K1, ST_C_OMK, ST_C_THR, ST_C_ACC, ST_C_P00, ST_C_P01,
    ST_C_P10, ST_C_P11, ST_C_CLAMP, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic [7:0] shift;
    logic lim32;
  } op_req_t;
endpackage

// ----- hw/rtl/htk_arith.sv -----
// Shared multiply-shift and divide-shift unit working one bit per cycle.
module htk_arith
  import htk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  op_req_t            req,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] result
);
  localparam logic [63:0] Lim48 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] Lim32 = 64'h0000_0000_7FFF_FFFF;

  logic         busy;
  logic         is_div;
  logic         neg;
  logic         sat32;
  logic [7:0]   shift;
  logic [7:0]   count;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [127:0] acc;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         over;
  logic [63:0]  lim;
  logic [127:0] shifted;
  logic [63:0]  mag;
  logic [64:0]  rem_sh;
  logic [63:0]  quo_sh;
  logic [63:0]  abs_a;
  logic [63:0]  abs_b;

  always_comb begin
    abs_a = a[63] ? 64'(-a) : 64'(a);
    abs_b = b[63] ? 64'(-b) : 64'(b);
    lim = sat32 ? Lim32 : Lim48;
    rem_sh = {rem, (count < 8'd64) ? ua[63 - count[5:0]] : 1'b0};
    quo_sh = {quo[62:0], 1'b0};
    shifted = acc >> shift;
    mag = (|shifted[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0];
    if (is_div) begin
      mag = quo;
    end
    if (mag > lim + {63'd0, neg}) begin
      mag = lim + {63'd0, neg};
    end
    result = neg ? 64'(-mag) : 64'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        is_div <= req.is_div;
        sat32 <= req.lim32;
        shift <= req.shift;
        neg <= req.is_div ? a[63] : (a[63] != b[63]);
        ua <= abs_a;
        ub <= req.is_div ? 64'(b) : abs_b;
        acc <= '0;
        rem <= '0;
        quo <= '0;
        over <= 1'b0;
        count <= '0;
      end else if (busy) begin
        if (!is_div) begin
          if (ub[count[5:0]]) begin
            acc <= acc + ({64'd0, ua} << count[5:0]);
          end
          count <= count + 8'd1;
          if (count == 8'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (!over) begin
            if (rem_sh >= {1'b0, ub}) begin
              rem <= 64'(rem_sh - {1'b0, ub});
              quo <= quo_sh | 64'd1;
              if ((quo_sh | 64'd1) > Lim48) begin
                quo <= Lim48 + 64'd1;
                over <= 1'b1;
              end
            end else begin
              rem <= rem_sh[63:0];
              quo <= quo_sh;
              if (quo_sh > Lim48) begin
                quo <= Lim48 + 64'd1;
                over <= 1'b1;
              end
            end
          end
          count <= count + 8'd1;
          if (count == 8'd63 + shift) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
endmodule

// ----- hw/rtl/hover_thrust_kalman_estimator_unit.sv -----
// Hover thrust estimator: a two-state Kalman filter with a shared arithmetic unit.
// Requests arrive on in_valid/in_stall with fields command and value; each
// request gives exactly one result on out_valid/out_stall with fields
// hover_thrust, accel_estimate and limit_hit. The block takes one request
// at a time: in_stall is high from acceptance until the result has been
// loaded into the output register.
// The shared unit handles one bit per cycle for multiply-shift and
// divide-shift alike. A predict request runs four multiplies; a correct
// request runs two divides and six multiplies; set and the unused command
// go straight to the output state.
// The output register holds its result while out_stall is high; the block
// may start the next request then, but does not load a new result until the
// previous one has been taken.
// Reset, synchronous and active high, loads the register defaults, clears the
// estimates and sets the covariance to 0.25 and 1.0 on the diagonal. The user must
// write configuration on cfg_we, cfg_index, cfg_data only while idle (unenforced).
`include "hover_thrust_kalman_estimator_unit_defines.svh"
module hover_thrust_kalman_estimator_unit
  import htk_pkg::*;
#(
  parameter int DATA_FRAC_BITS = DataFracBits,
  parameter int COV_FRAC_BITS = CovFracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] hover_thrust,
  output logic signed [31:0] accel_estimate,
  output logic [1:0]         limit_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);
  localparam logic signed [63:0] Lim48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Min48 = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] Lim32 = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] Min32 = -64'sh8000_0000;
  localparam logic [7:0] DShift = 8'(DATA_FRAC_BITS);
  localparam logic [7:0] CShift = 8'(COV_FRAC_BITS);

  logic [22:0] reg_gain;
  logic [16:0] reg_lo;
  logic [16:0] reg_hi;
  logic [24:0] reg_noise;
  logic [20:0] reg_grav;

  logic signed [31:0] thr;
  logic signed [31:0] acc;
  logic signed [47:0] p00, p01, p10, p11;
  logic signed [63:0] t0, t1, t2, yv;
  logic [1:0]  cmd;
  logic signed [31:0] val;
  logic [1:0]  flag;

  state_t state, state_next;
  logic   issued;
  op_req_t req;
  logic signed [63:0] opa, opb;
  logic   op_done;
  logic signed [63:0] op_res;

  function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                             input logic signed [63:0] hi_v,
                                             input logic signed [63:0] lo_v);
    sat = (v > hi_v) ? hi_v : ((v < lo_v) ? lo_v : v);
  endfunction

  htk_arith u_arith (
    .clk(clk), .rst(rst), .req(req), .a(opa), .b(opb),
    .done(op_done), .result(op_res)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (command)
            CMD_PREDICT: state_next = ST_P_G2;
            CMD_CORRECT: state_next = ST_C_S;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_P_G2: if (op_done) state_next = ST_P_OFF;
      ST_P_OFF: if (op_done) state_next = ST_P_ACC;
      ST_P_ACC: if (op_done) state_next = ST_P_P11;
      ST_P_P11: if (op_done) state_next = ST_OUT;
      ST_C_S: state_next = ((64'(p11) + 64'($signed({1'b0, reg_noise}))) <= 0) ?
                           ST_C_CLAMP : ST_C_K0;
      ST_C_K0: if (op_done) state_next = ST_C_K1;
      ST_C_K1: if (op_done) state_next = ST_C_THR;
      ST_C_THR: if (op_done) state_next = ST_C_ACC;
      ST_C_ACC: if (op_done) state_next = ST_C_OMK;
      ST_C_OMK: state_next = ST_C_P00;
      ST_C_P00: if (op_done) state_next = ST_C_P01;
      ST_C_P01: if (op_done) state_next = ST_C_P10;
      ST_C_P10: if (op_done) state_next = ST_C_P11;
      ST_C_P11: if (op_done) state_next = ST_C_CLAMP;
      ST_C_CLAMP: state_next = ST_OUT;
      ST_OUT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    opa = '0;
    opb = '0;
    req.start = !issued;
    req.shift = DShift;
    unique case (state)
      ST_P_G2: begin opa = 64'(reg_gain); opb = 64'(reg_gain); end
      ST_P_OFF: begin opa = 64'(reg_gain); opb = 64'(p00); end
      ST_P_ACC: begin
        opa = 64'(reg_gain); opb = 64'(val) - 64'(thr); req.lim32 = 1'b1;
      end
      ST_P_P11: begin opa = t0; opb = 64'(p00); end
      ST_C_K0: begin
        opa = 64'(p01); opb = t2; req.is_div = 1'b1; req.shift = CShift;
      end
      ST_C_K1: begin
        opa = 64'(p11); opb = t2; req.is_div = 1'b1; req.shift = CShift;
      end
      ST_C_THR: begin opa = t0; opb = yv; req.shift = CShift; req.lim32 = 1'b1; end
      ST_C_ACC: begin opa = t1; opb = yv; req.shift = CShift; req.lim32 = 1'b1; end
      ST_C_P00: begin opa = t0; opb = 64'(p10); req.shift = CShift; end
      ST_C_P01: begin opa = t0; opb = 64'(p11); req.shift = CShift; end
      ST_C_P10: begin opa = t1; opb = 64'(p10); req.shift = CShift; end
      ST_C_P11: begin opa = t1; opb = 64'(p11); req.shift = CShift; end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
      out_valid <= 1'b0;
      reg_gain <= 23'd1310720;
      reg_lo <= 17'd6554;
      reg_hi <= 17'd58982;
      reg_noise <= 25'd17;
      reg_grav <= 21'd642253;
      thr <= '0;
      acc <= '0;
      p00 <= 48'sd1 <<< (COV_FRAC_BITS - 2);
      p01 <= '0;
      p10 <= '0;
      p11 <= 48'sd1 <<< COV_FRAC_BITS;
    end else begin
      state <= state_next;
      if (req.start) issued <= 1'b1;
      if (op_done) issued <= 1'b0;
      if (out_valid && !out_stall && (state != ST_OUT)) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN: reg_gain <= cfg_data[22:0];
          REG_LO: reg_lo <= cfg_data[16:0];
          REG_HI: reg_hi <= cfg_data[16:0];
          REG_NOISE: reg_noise <= cfg_data;
          REG_GRAV: reg_grav <= cfg_data[20:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          cmd <= command;
          val <= value;
          flag <= FLAG_NONE;
        end
        ST_P_G2: if (op_done) t0 <= op_res;
        ST_P_OFF: if (op_done) t1 <= sat(-op_res, Lim48, Min48);
        ST_P_ACC: if (op_done) acc <= 32'(op_res);
        ST_P_P11: if (op_done) begin
          p01 <= 48'(t1);
          p10 <= 48'(t1);
          p11 <= 48'(op_res);
        end
        ST_C_S: begin
          t2 <= 64'(p11) + 64'(reg_noise);
          yv <= (64'(val) - 64'(reg_grav)) - 64'(acc);
          if ((64'(p11) + 64'($signed({1'b0, reg_noise}))) <= 0) flag <= FLAG_ZERO_VAR;
        end
        ST_C_K0: if (op_done) t0 <= op_res;
        ST_C_K1: if (op_done) t1 <= op_res;
        ST_C_OMK: t1 <= sat((64'sd1 <<< COV_FRAC_BITS) - t1, Lim48, Min48);
        ST_C_THR: if (op_done) thr <= 32'(sat(64'(thr) + op_res, Lim32, Min32));
        ST_C_ACC: if (op_done) acc <= 32'(sat(64'(acc) + op_res, Lim32, Min32));
        ST_C_P00: if (op_done) p00 <= 48'(sat(64'(p00) - op_res, Lim48, Min48));
        ST_C_P01: if (op_done) t2 <= sat(64'(p01) - op_res, Lim48, Min48);
        ST_C_P10: if (op_done) t0 <= op_res;
        ST_C_P11: if (op_done) begin
          p01 <= 48'(t2);
          p10 <= 48'(t0);
          p11 <= 48'(op_res);
        end
        ST_C_CLAMP: begin
          if (thr < 32'($signed({1'b0, reg_lo}))) begin
            thr <= 32'(reg_lo);
            if (flag == FLAG_NONE) flag <= FLAG_LOW;
          end else if (thr > 32'($signed({1'b0, reg_hi}))) begin
            thr <= 32'(reg_hi);
            if (flag == FLAG_NONE) flag <= FLAG_HIGH;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            hover_thrust <= (cmd == CMD_SET) ? val : thr;
            accel_estimate <= acc;
            limit_hit <= flag;
            if (cmd == CMD_SET) thr <= val;
          end
        end
        default: ;
      endcase
    end
  end

  `HTK_ASSERT_IMP(a_busy_stall, state != ST_IDLE, in_stall)
  `HTK_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(hover_thrust))
  `HTK_ASSERT_IMP(a_done_busy, op_done, state != ST_IDLE)
endmodule
